// File: rtl/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and constants for the servo ramp interpolator.
// ----------------------------------------------------------------------------
package srp_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_ZERO  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_FULL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_MOVE = 3'd4;
	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic [15:0] RST_TIMEOUT   = 16'd5000;
	localparam logic [7:0]  RST_DEFAULT   = 8'd0;
	localparam logic [7:0]  RST_POS_ZERO  = 8'd106;
	localparam logic [7:0]  RST_POS_FULL  = 8'd0;
	localparam logic [15:0] RST_FULL_MOVE = 16'd1000;

	// full channel range and the bias that turns floor into ceiling for it
	localparam logic [15:0] FULL_RANGE = 16'd255;
	localparam logic [7:0]  CEIL_BIAS  = 8'd254;

	// serial multiply/divide unit: 16 x 8 product plus bias, 24-bit dividend
	localparam int MD_A_W       = 16;
	localparam int MD_B_W       = 8;
	localparam int MD_ACC_W     = MD_A_W + MD_B_W;
	localparam int MD_MUL_STEPS = MD_B_W;
	localparam int MD_DIV_STEPS = MD_ACC_W;
	localparam int MD_CNT_W     = $clog2(MD_DIV_STEPS);

	typedef struct packed {
		logic [7:0]  channel_value;
		logic [15:0] silence_ms;
	} srp_in_t;

	typedef struct packed {
		logic [7:0] servo_pos;
		logic       moving;
		logic       link_lost;
	} srp_out_t;

	// request to the multiply/divide unit: floor((a * b + bias) / divisor)
	typedef struct packed {
		logic [MD_A_W-1:0] a;
		logic [MD_B_W-1:0] b;
		logic [7:0]        bias;
		logic [15:0]       divisor;
	} md_req_t;

endpackage

// File: rtl/srp_muldiv.sv
// ----------------------------------------------------------------------------
// srp_muldiv
// Bit-serial multiply then restoring divide: floor((a*b + bias) / divisor).
// ----------------------------------------------------------------------------
module srp_muldiv import srp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  md_req_t     req,
	output logic        done,
	output logic [15:0] quot
);

	logic [MD_ACC_W-1:0] a_sh_q;
	logic [MD_B_W-1:0]   b_sh_q;
	logic [MD_ACC_W-1:0] acc_q;
	logic [15:0]         rem_q;
	logic [15:0]         div_q;
	logic [MD_CNT_W-1:0] cnt_q;
	logic                busy_q;
	logic                div_ph_q;
	logic                done_q;

	logic [16:0] trial;
	logic        ge;

	// one quotient bit per step: remainder shifts in the next dividend bit
	assign trial = {rem_q, acc_q[MD_ACC_W-1]};
	assign ge    = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_sh_q   <= '0;
			b_sh_q   <= '0;
			acc_q    <= '0;
			rem_q    <= '0;
			div_q    <= '0;
			cnt_q    <= '0;
			busy_q   <= 1'b0;
			div_ph_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_sh_q   <= MD_ACC_W'(req.a);
				b_sh_q   <= req.b;
				acc_q    <= MD_ACC_W'(req.bias);
				div_q    <= req.divisor;
				rem_q    <= '0;
				cnt_q    <= '0;
				busy_q   <= 1'b1;
				div_ph_q <= 1'b0;
			end else if (busy_q && !div_ph_q) begin
				// shift-add, one multiplier bit per cycle
				if (b_sh_q[0]) begin
					acc_q <= acc_q + a_sh_q;
				end
				a_sh_q <= a_sh_q << 1;
				b_sh_q <= b_sh_q >> 1;
				if (cnt_q == MD_CNT_W'(MD_MUL_STEPS - 1)) begin
					cnt_q    <= '0;
					div_ph_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (busy_q) begin
				rem_q <= ge ? 16'(trial - {1'b0, div_q}) : trial[15:0];
				acc_q <= {acc_q[MD_ACC_W-2:0], ge};
				if (cnt_q == MD_CNT_W'(MD_DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = acc_q[15:0];

endmodule

// File: rtl/servo_ramp_interpolator.sv
// ----------------------------------------------------------------------------
// servo_ramp_interpolator
// Linear servo position ramp, one item per millisecond tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_data  : one item per tick (channel value, ms since last packet).
//   out_data : one item per input item (position, moving, link lost).
//   Both channels are valid/stall; an item moves when valid is high and
//   stall is low. cfg_we/cfg_index/cfg_data write a register;
//   write only while the block is idle.
//   Each division runs in the shared serial multiply/divide unit
//   (8 multiply steps + 24 divide steps); an item needs zero to four of them.
//   One item is worked on at a time; in_stall is high until it is done.
//   The result sits in an output register, so the next item is taken while
//   a finished result waits on out_stall. If the previous result is still
//   held, the new one waits in the last step before release.
//   Reset: registers take their defaults, tick counter and ramp state clear,
//   and the first item always starts a ramp.
// ----------------------------------------------------------------------------
module servo_ramp_interpolator import srp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  srp_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output srp_out_t              out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_BEGIN  = 3'd2; // position reached by old ramp
	localparam logic [2:0] ST_GOAL   = 3'd3; // map value to goal position
	localparam logic [2:0] ST_LEN    = 3'd4; // ramp length
	localparam logic [2:0] ST_PICK   = 3'd5;
	localparam logic [2:0] ST_POS    = 3'd6; // interpolated position
	localparam logic [2:0] ST_DONE   = 3'd7;

	// configuration
	logic [15:0] timeout_q;
	logic [7:0]  default_q;
	logic [7:0]  pos_zero_q;
	logic [7:0]  pos_full_q;
	logic [15:0] full_move_q;

	// ramp state
	logic [31:0] now_q;
	logic [31:0] ramp_start_q;
	logic [31:0] ramp_end_q;
	logic [15:0] dur_q;       // ramp_end - ramp_start, always fits 16 bits
	logic [7:0]  start_pos_q;
	logic [7:0]  goal_pos_q;
	logic [7:0]  last_q;
	logic        have_q;

	// current item
	logic [2:0]  state_q;
	logic        issue_q;
	logic [7:0]  v_q;
	logic        lost_q;
	logic        need_q;
	logic [7:0]  pos_q;
	logic        mov_q;

	logic        out_valid_q;
	srp_out_t    out_q;

	// unit interface
	md_req_t     md_req;
	logic        md_done;
	logic [15:0] md_quot;

	// interpolation operands
	logic [31:0] el;
	logic [15:0] el_c;
	logic [8:0]  rdiff;
	logic [7:0]  rmag;
	logic [8:0]  gdiff;
	logic [7:0]  gmag;
	logic [7:0]  delta;
	logic [7:0]  q8;
	logic [7:0]  rpos_res;
	logic [7:0]  goal_res;
	logic        in_accept;
	logic        out_free;
	logic        in_ramp;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_ramp   = (now_q <= ramp_end_q);

	// elapsed time clamped to ramp length
	assign el    = now_q - ramp_start_q;
	assign el_c  = (el > {16'd0, dur_q}) ? dur_q : el[15:0];
	assign rdiff = {1'b0, goal_pos_q} - {1'b0, start_pos_q};
	assign rmag  = rdiff[8] ? 8'(-rdiff) : rdiff[7:0];

	// goal mapping: negative slope rounds toward minus infinity via ceiling
	assign gdiff = {1'b0, pos_full_q} - {1'b0, pos_zero_q};
	assign gmag  = gdiff[8] ? 8'(-gdiff) : gdiff[7:0];

	assign delta = (v_q >= last_q) ? (v_q - last_q) : (last_q - v_q);

	assign q8       = md_quot[7:0];
	assign rpos_res = rdiff[8] ? (start_pos_q - q8) : (start_pos_q + q8);
	assign goal_res = gdiff[8] ? (pos_zero_q - q8) : (pos_zero_q + q8);

	always_comb begin
		unique case (state_q)
			ST_GOAL: begin
				md_req.a       = MD_A_W'(v_q);
				md_req.b       = gmag;
				md_req.bias    = gdiff[8] ? CEIL_BIAS : 8'd0;
				md_req.divisor = FULL_RANGE;
			end
			ST_LEN: begin
				md_req.a       = full_move_q;
				md_req.b       = delta;
				md_req.bias    = 8'd0;
				md_req.divisor = FULL_RANGE;
			end
			default: begin
				md_req.a       = el_c;
				md_req.b       = rmag;
				md_req.bias    = 8'd0;
				md_req.divisor = dur_q;
			end
		endcase
	end

	srp_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (issue_q),
		.req    (md_req),
		.done   (md_done),
		.quot   (md_quot)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= RST_TIMEOUT;
			default_q   <= RST_DEFAULT;
			pos_zero_q  <= RST_POS_ZERO;
			pos_full_q  <= RST_POS_FULL;
			full_move_q <= RST_FULL_MOVE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMEOUT:   timeout_q   <= cfg_data;
				CFG_DEFAULT:   default_q   <= cfg_data[7:0];
				CFG_POS_ZERO:  pos_zero_q  <= cfg_data[7:0];
				CFG_POS_FULL:  pos_full_q  <= cfg_data[7:0];
				CFG_FULL_MOVE: full_move_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issue_q      <= 1'b0;
			now_q        <= '0;
			ramp_start_q <= '0;
			ramp_end_q   <= '0;
			dur_q        <= '0;
			start_pos_q  <= '0;
			goal_pos_q   <= '0;
			last_q       <= '0;
			have_q       <= 1'b0;
			v_q          <= '0;
			lost_q       <= 1'b0;
			need_q       <= 1'b0;
			pos_q        <= '0;
			mov_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			issue_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (in_data.silence_ms < timeout_q) begin
							v_q    <= in_data.channel_value;
							lost_q <= 1'b0;
							need_q <= !have_q || (in_data.channel_value != last_q);
						end else begin
							v_q    <= default_q;
							lost_q <= 1'b1;
							need_q <= !have_q || (default_q != last_q);
						end
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!need_q) begin
						state_q <= ST_PICK;
					end else if (in_ramp && dur_q != 16'd0) begin
						issue_q <= 1'b1;
						state_q <= ST_BEGIN;
					end else begin
						// ramp over or zero length: start from the goal
						start_pos_q <= goal_pos_q;
						issue_q     <= 1'b1;
						state_q     <= ST_GOAL;
					end
				end
				ST_BEGIN: begin
					if (md_done) begin
						start_pos_q <= rpos_res;
						issue_q     <= 1'b1;
						state_q     <= ST_GOAL;
					end
				end
				ST_GOAL: begin
					if (md_done) begin
						goal_pos_q <= goal_res;
						issue_q    <= 1'b1;
						state_q    <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (md_done) begin
						ramp_start_q <= now_q;
						ramp_end_q   <= now_q + 32'(md_quot);
						dur_q        <= md_quot;
						last_q       <= v_q;
						have_q       <= 1'b1;
						state_q      <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (in_ramp && dur_q != 16'd0) begin
						issue_q <= 1'b1;
						state_q <= ST_POS;
					end else begin
						pos_q   <= goal_pos_q;
						mov_q   <= in_ramp;
						state_q <= ST_DONE;
					end
				end
				ST_POS: begin
					if (md_done) begin
						pos_q   <= rpos_res;
						mov_q   <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q.servo_pos <= pos_q;
						out_q.moving    <= mov_q;
						out_q.link_lost <= lost_q;
						out_valid_q     <= 1'b1;
						now_q           <= now_q + 32'd1;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
